@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the priority queue core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define MPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define MPQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/mpq_pkg.sv @@
// ---------------------------------------------------------------------------
// mpq_pkg
// Types and constants of the unsorted-array max priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    // Operation codes carried in the mode field
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Marker for "no value"
    localparam logic signed [31:0] NONE_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Result word handed from the core to the output register
    typedef struct packed {
        status_t            status;
        logic signed [31:0] removed_value;
        logic signed [31:0] max_value;
        logic [7:0]         count;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/mpq_item_if.sv @@
// ---------------------------------------------------------------------------
// mpq_item_if
// Valid/ready channel carrying one queue operation word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpq_item_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/mpq_result_if.sv @@
// ---------------------------------------------------------------------------
// mpq_result_if
// Valid/ready channel carrying one queue result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mpq_result_if;
    import mpq_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] max_value;
    logic [7:0]         count;

    modport source (output valid, output status, output removed_value,
                    output max_value, output count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input max_value, input count, output ready);
endinterface

`default_nettype wire

@@ hdl/mpq_ram.sv @@
// ---------------------------------------------------------------------------
// mpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/mpq_core.sv @@
// ---------------------------------------------------------------------------
// mpq_core
// Sequencer of the queue: appends on insert, and on a non-empty remove makes one pass
// over the store that finds the first maximum, shifts the tail down and
// gathers the new maximum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpq_core #(
    parameter int CAPACITY = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    mpq_item_if.sink                         item,
    input  wire logic                        slot_free,
    output      logic                        res_valid,
    output      mpq_pkg::res_t               res,
    output      logic                        ram_wr_en,
    output      logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
    output      logic [31:0]                 ram_wr_data,
    output      logic                        ram_rd_en,
    output      logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
    input  wire logic [31:0]                 ram_rd_data
);

    import mpq_pkg::*;

`include "assert_macros.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t             state_reg, state_next;
    logic               mode_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg;
    logic signed [31:0] max_reg;
    logic [CW-1:0]      rd_addr_reg;
    logic               dv_reg;
    logic [CW-1:0]      d_addr_reg;
    logic               found_reg;
    logic signed [31:0] nm_reg;
    logic               nmv_reg;

    logic               accept;
    logic               start_scan;
    logic               issue;
    logic               last;
    logic               hit;
    logic               keep;
    logic               finish_fire;
    logic               full;
    logic               empty;
    logic               ins_ok;
    logic               rem_ok;
    logic signed [31:0] ins_max;
    logic signed [31:0] rd_val;
    logic [CW-1:0]      shift_addr;
    logic [CW-1:0]      count_new;
    logic signed [31:0] max_new;
    logic [CW+7:0]      cnt_ext;

    // Scan bookkeeping
    assign accept      = item.valid && item.ready;
    assign full        = (count_reg >= CAP_C);
    assign empty       = (count_reg == '0);
    assign start_scan  = accept && (item.mode == MODE_REMOVE) && !empty;
    assign issue       = (state_reg == S_SCAN) && (rd_addr_reg < count_reg);
    assign rd_val      = $signed(ram_rd_data);
    assign last        = dv_reg && (d_addr_reg == count_reg - 1'b1);
    assign hit         = dv_reg && !found_reg && (rd_val == max_reg);
    assign keep        = dv_reg && !hit;
    assign shift_addr  = d_addr_reg - 1'b1;
    assign finish_fire = (state_reg == S_FINISH) && slot_free;
    assign ins_ok      = (mode_reg == MODE_INSERT) && !full;
    assign rem_ok      = (mode_reg == MODE_REMOVE) && !empty;
    assign ins_max     = (empty || (value_reg > max_reg)) ? value_reg : max_reg;

    // Memory ports: reads run ahead, shift writes trail one place behind
    assign ram_rd_en   = issue;
    assign ram_rd_addr = rd_addr_reg[AW-1:0];
    assign ram_wr_en   = (dv_reg && found_reg) || (finish_fire && ins_ok);
    assign ram_wr_addr = (state_reg == S_FINISH) ? count_reg[AW-1:0] : shift_addr[AW-1:0];
    assign ram_wr_data = (state_reg == S_FINISH) ? value_reg : ram_rd_data;

    // Next state and result word
    always_comb
    begin
        state_next = state_reg;
        item.ready = 1'b0;
        res_valid  = 1'b0;
        count_new  = count_reg;
        max_new    = max_reg;
        res.status = ST_OK;
        res.removed_value = NONE_VALUE;

        if (ins_ok)
        begin
            count_new = count_reg + 1'b1;
            max_new   = ins_max;
        end
        else if (rem_ok)
        begin
            count_new = count_reg - 1'b1;
            max_new   = nmv_reg ? nm_reg : NONE_VALUE;
            res.removed_value = max_reg;
        end
        else if (mode_reg == MODE_INSERT)
        begin
            res.status = ST_OVERFLOW;
        end
        else
        begin
            res.status = ST_EMPTY;
        end

        cnt_ext       = {8'b0, count_new};
        res.max_value = max_new;
        res.count     = cnt_ext[7:0];

        case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    state_next = start_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Queue state: count and current maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= NONE_VALUE;
        end
        else if (finish_fire)
        begin
            count_reg <= count_new;
            max_reg   <= max_new;
        end
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            dv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            nmv_reg     <= 1'b0;
        end
        else
        begin
            dv_reg <= issue;
            if (start_scan)
            begin
                rd_addr_reg <= '0;
                found_reg   <= 1'b0;
                nmv_reg     <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                if (keep)
                begin
                    nmv_reg <= 1'b1;
                end
            end
        end
    end

    // Item hold and scan data path
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= item.mode;
            value_reg <= item.value;
        end
        d_addr_reg <= rd_addr_reg;
        if (keep && (!nmv_reg || (rd_val > nm_reg)))
        begin
            nm_reg <= rd_val;
        end
    end

    `MPQ_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CAP_C, "count beyond capacity")
    `MPQ_ASSERT(a_read_in_range, clk, rst_n, dv_reg |-> (d_addr_reg < count_reg), "scan read past the last entry")
    `MPQ_ASSERT(a_max_found, clk, rst_n, (state_reg == S_FINISH && rem_ok) |-> found_reg, "stored maximum not found in scan")
    `MPQ_ASSERT(a_shift_behind, clk, rst_n, (dv_reg && found_reg) |-> (d_addr_reg != '0), "shift write below entry zero")

endmodule

`default_nettype wire

@@ hdl/max_priority_queue_unsorted_unit.sv @@
// ---------------------------------------------------------------------------
// max_priority_queue_unsorted_unit
// Max priority queue kept as an unsorted array in one RAM.
// ---------------------------------------------------------------------------
//  channel   dir   word
//  item      in    mode (0 insert, 1 remove), value
//  result    out   status, removed_value, max_value, count
//
//  Insert and any failed remove go from acceptance straight to the finish state and
//  then into the output register. A remove first makes one pass over the stored
//  entries through the RAM read port, with the shift write trailing one place behind.
//  The current maximum is held in a register, so inserts need no scan.
//  Reset clears the count and the maximum; RAM contents need no clearing.
//  A finished result waits in the output register; a new item is taken then.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_priority_queue_unsorted_unit #(
    parameter int CAPACITY = 128
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mpq_item_if.sink     item,
    mpq_result_if.source result
);

    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          slot_free;
    logic          res_valid;
    res_t          res;
    res_t          res_reg;
    logic          out_valid_reg;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    mpq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .slot_free   (slot_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    mpq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || result.ready;

    // Output valid: load on a new word, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = res_reg.status;
    assign result.removed_value = res_reg.removed_value;
    assign result.max_value     = res_reg.max_value;
    assign result.count         = res_reg.count;

endmodule

`default_nettype wire
